// File: sv/lrutc_pkg.sv
// lrutc_pkg: shared types and constants of the lru tag cache directory
// used by lrutc_cell, lru_tag_cache_sorted_index and the testbench, no dependencies
package lrutc_pkg;

  localparam int TAG_W      = 64;
  localparam int SERIAL_W   = 56;
  localparam int SPACE_W    = 8;
  localparam int SLOT_OUT_W = 6;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 64;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_SPACE_INDEX   = 2'd0;
  localparam logic [1:0] REG_EMPTY_CODE    = 2'd1;
  localparam logic [1:0] REG_UNKNOWN_CODE  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_ROTATE = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     shift_en;
  } cell_ctl_t;

endpackage

// File: sv/lru_tag_cache_sorted_index.sv
// lru_tag_cache_sorted_index: fully associative lru tag directory, top level
// depends on lrutc_pkg and lrutc_cell
//
// Usage:
// - request channel (in_valid_i / in_stall_o) takes one word: a tag and an
//   allocate flag. An allocating request with the empty code gets a generated
//   tag from the serial counter and space_index.
// - result channel (out_valid_o / out_stall_i) returns one word per request:
//   present, hit, slot and final tag. The result sits in an output register.
// - slots are kept in a row of 2^INDEX_BITS-1 cells ordered by recency, cell 0
//   most recent. A lookup rotates the row once past the comparator at cell 0,
//   then ST_UPDATE moves the hit entry (or the evicted back entry) to cell 0.
// - the search rotates the row one cell at a time through all cells;
//   a sentinel tag (empty or unknown code) skips search and update and goes
//   straight to the result.
// - one request at a time: in_stall_o is high from accept until the result is
//   loaded into the output register; a result waiting on out_stall_i does not
//   block the next request, but the one after it waits.
// - reset: cell i: slot i, tag i; serial, empty code 0; unknown code all ones.
//   The user must write registers over the apb port while idle (unenforced).
module lru_tag_cache_sorted_index #(
  parameter int INDEX_BITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lrutc_pkg::TAG_W-1:0]       request_tag_i,
  input  logic                              allocate_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              present_o,
  output logic                              hit_o,
  output logic [lrutc_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic [lrutc_pkg::TAG_W-1:0]       final_tag_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrutc_pkg::PADDR_W-1:0]     paddr,
  input  logic [lrutc_pkg::PDATA_W-1:0]     pwdata,
  output logic [lrutc_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import lrutc_pkg::*;

  localparam int Slots = (1 << INDEX_BITS) - 1;
  localparam int ExtW  = (INDEX_BITS > SLOT_OUT_W) ? INDEX_BITS : SLOT_OUT_W;
  localparam logic [INDEX_BITS-1:0] LastCnt = INDEX_BITS'(Slots - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]            state_d, state_q;
  logic [TAG_W-1:0]      req_tag_q;
  logic                  req_alloc_q;
  logic                  sent_q;
  logic                  hit_d, hit_q;
  logic [INDEX_BITS-1:0] hit_k_d, hit_k_q;
  logic [INDEX_BITS-1:0] hit_slot_d, hit_slot_q;
  logic [INDEX_BITS-1:0] cnt_d, cnt_q;
  logic [SERIAL_W-1:0]   serial_q;
  logic [SPACE_W-1:0]    space_q;
  logic [TAG_W-1:0]      empty_q, unknown_q;
  logic                  out_valid_q, present_q, hit_out_q;
  logic [INDEX_BITS-1:0] slot_out_q;
  logic [TAG_W-1:0]      tag_out_q;

  logic                  in_acc, gen, sentinel, out_load, cfg_wr;
  logic [TAG_W-1:0]      tag_d;
  logic [ExtW-1:0]       slot_ext;

  // recency row
  cell_ctl_t             ctl [Slots];
  logic [INDEX_BITS-1:0] cslot [Slots];
  logic [TAG_W-1:0]      ctag [Slots];
  cell_op_e              row_op;
  logic [INDEX_BITS-1:0] ins_slot;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q   <= '0;
      empty_q   <= '0;
      unknown_q <= '1;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_SPACE_INDEX:  space_q   <= pwdata[SPACE_W-1:0];
        REG_EMPTY_CODE:   empty_q   <= pwdata;
        REG_UNKNOWN_CODE: unknown_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_SPACE_INDEX:  prdata = PDATA_W'(space_q);
      REG_EMPTY_CODE:   prdata = empty_q;
      REG_UNKNOWN_CODE: prdata = unknown_q;
      default:          prdata = '0;
    endcase
  end

  // request intake, tag generation and sentinel check
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign gen        = allocate_i && (request_tag_i == empty_q);
  assign tag_d      = gen ? {space_q, serial_q} : request_tag_i;
  assign sentinel   = (tag_d == empty_q) || (tag_d == unknown_q);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    hit_d      = hit_q;
    hit_k_d    = hit_k_q;
    hit_slot_d = hit_slot_q;
    cnt_d      = cnt_q;
    row_op     = CELL_HOLD;
    ins_slot   = hit_slot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hit_d   = 1'b0;
          cnt_d   = '0;
          state_d = sentinel ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        row_op = CELL_ROTATE;
        if (!hit_q && (ctag[0] == req_tag_q)) begin
          hit_d      = 1'b1;
          hit_k_d    = cnt_q;
          hit_slot_d = cslot[0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (hit_q) begin
          row_op = CELL_SHIFT;
        end else if (req_alloc_q) begin
          row_op     = CELL_SHIFT;
          ins_slot   = cslot[Slots-1];
          hit_slot_d = cslot[Slots-1];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hit_q    <= 1'b0;
      cnt_q    <= '0;
      serial_q <= '0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
      cnt_q   <= cnt_d;
      if (in_acc && gen) begin
        serial_q <= serial_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_k_q    <= hit_k_d;
    hit_slot_q <= hit_slot_d;
    if (in_acc) begin
      req_tag_q   <= tag_d;
      req_alloc_q <= allocate_i;
      sent_q      <= sentinel;
    end
  end

  // row of cells: rotate toward cell 0, shift away from cell 0
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    logic [INDEX_BITS-1:0] dn_slot;
    logic [TAG_W-1:0]      dn_tag;

    if (i == 0) begin : g_head
      assign dn_slot = ins_slot;
      assign dn_tag  = req_tag_q;
    end else begin : g_body
      assign dn_slot = cslot[i-1];
      assign dn_tag  = ctag[i-1];
    end

    assign ctl[i].op       = row_op;
    assign ctl[i].shift_en = hit_q ? (INDEX_BITS'(i) <= hit_k_q) : 1'b1;

    lrutc_cell #(
      .IndexBits (INDEX_BITS),
      .CellIdx   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[i]),
      .up_slot_i (cslot[(i + 1) % Slots]),
      .up_tag_i  (ctag[(i + 1) % Slots]),
      .dn_slot_i (dn_slot),
      .dn_tag_i  (dn_tag),
      .slot_o    (cslot[i]),
      .tag_o     (ctag[i])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      present_q  <= !sent_q && (hit_q || req_alloc_q);
      hit_out_q  <= !sent_q && hit_q;
      slot_out_q <= (!sent_q && (hit_q || req_alloc_q)) ? hit_slot_q : '0;
      tag_out_q  <= req_tag_q;
    end
  end

  assign slot_ext    = ExtW'(slot_out_q);
  assign out_valid_o = out_valid_q;
  assign present_o   = present_q;
  assign hit_o       = hit_out_q;
  assign slot_o      = slot_ext[SLOT_OUT_W-1:0];
  assign final_tag_o = tag_out_q;

  // checks
  a_hit_is_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> present_o)
    else $error("hit reported without a slot");

  a_absent_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !present_o |-> slot_o == '0)
    else $error("slot nonzero on an absent result");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after a request");

endmodule

// File: sv/lrutc_cell.sv
// lrutc_cell: one entry of the recency row, holds a slot number and its tag
// depends on lrutc_pkg
module lrutc_cell #(
  parameter int IndexBits = 6,
  parameter int CellIdx   = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lrutc_pkg::cell_ctl_t     ctl_i,
  input  logic [IndexBits-1:0]     up_slot_i,
  input  logic [lrutc_pkg::TAG_W-1:0] up_tag_i,
  input  logic [IndexBits-1:0]     dn_slot_i,
  input  logic [lrutc_pkg::TAG_W-1:0] dn_tag_i,
  output logic [IndexBits-1:0]     slot_o,
  output logic [lrutc_pkg::TAG_W-1:0] tag_o
);
  import lrutc_pkg::*;

  logic [IndexBits-1:0] slot_d, slot_q;
  logic [TAG_W-1:0]     tag_d, tag_q;

  // rotate takes the entry behind, shift takes the entry in front
  always_comb begin
    slot_d = slot_q;
    tag_d  = tag_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_ROTATE: begin
        slot_d = up_slot_i;
        tag_d  = up_tag_i;
      end
      CELL_SHIFT: begin
        if (ctl_i.shift_en) begin
          slot_d = dn_slot_i;
          tag_d  = dn_tag_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= IndexBits'(CellIdx);
      tag_q  <= TAG_W'(CellIdx);
    end else begin
      slot_q <= slot_d;
      tag_q  <= tag_d;
    end
  end

  assign slot_o = slot_q;
  assign tag_o  = tag_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for lru_tag_cache_sorted_index
// depends on lrutc_pkg and the directory rtl; holds its own lru directory predictor
module testbench;
  import lrutc_pkg::*;

  localparam int IB    = 6;
  localparam int NSLOT = (1 << IB) - 1;
  localparam int LIMIT = 600000;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             alloc;
  } req_t;

  typedef struct packed {
    logic                  present;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [TAG_W-1:0]      tag;
  } resp_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [TAG_W-1:0] req_tag = '0;
  logic req_alloc = 0;
  logic in_stall, out_valid, present, hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic [TAG_W-1:0] final_tag;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0, prdata;
  logic pready;

  lru_tag_cache_sorted_index #(.INDEX_BITS(IB)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .request_tag_i(req_tag), .allocate_i(req_alloc),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .present_o(present), .hit_o(hit), .slot_o(slot), .final_tag_o(final_tag),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // directory model state
  logic [SPACE_W-1:0]  space_idx;
  logic [TAG_W-1:0]    empty_code, unknown_code;
  logic [TAG_W-1:0]    tag_of [64];
  logic [IB-1:0]       order_slot [64];
  logic [IB-1:0]       older [64];
  logic [IB-1:0]       newer [64];
  logic [IB-1:0]       mru, lru;
  logic [SERIAL_W-1:0] serial;

  req_t  pend_words[$];
  resp_t expected_words[$];
  logic [TAG_W-1:0] tag_pool[$];
  int errors = 0, cycles = 0, gap_cnt = 0, stall_cnt = 0;
  bit no_idle = 0;

  // move slot s to the most recent end of the recency list
  task automatic touch_slot(input logic [IB-1:0] s);
    if (s != mru) begin
      if (s == lru) lru = older[s];
      else begin
        newer[older[s]] = newer[s];
        older[newer[s]] = older[s];
      end
      older[mru] = s;
      newer[s] = mru;
      mru = s;
    end
  endtask

  // look up one request, update the directory and queue its result word
  task automatic lookup_word(input req_t w);
    logic [TAG_W-1:0] t, probe;
    logic [IB-1:0] pos, s;
    int step, q, p, tgt, n;
    resp_t r;
    t = w.tag;
    probe = '0;
    if (w.alloc && t == empty_code) begin
      t = {space_idx, serial};
      serial = serial + 1'b1;
    end
    r = '{present: 1'b0, hit: 1'b0, slot: '0, tag: t};
    if (t != empty_code && t != unknown_code) begin
      step = 1 << (IB - 1);
      pos = IB'(step - 1);
      do begin
        s = order_slot[pos];
        probe = tag_of[s];
        if (probe == t) begin
          touch_slot(s);
          r.present = 1'b1; r.hit = 1'b1; r.slot = s;
          expected_words.push_back(r);
          return;
        end
        step = step >> 1;
        pos = (t < probe) ? pos - IB'(step) : pos + IB'(step);
      end while (step != 0);
      if (w.alloc) begin
        q = int'(pos) + ((probe < t) ? 1 : 0);
        s = lru;
        p = NSLOT - 1;
        for (n = 0; n < NSLOT; n++)
          if (order_slot[n] == s) begin
            p = n;
            break;
          end
        tgt = (p < q) ? q - 1 : q;
        if (tgt > NSLOT - 1) tgt = NSLOT - 1;
        if (p < tgt) for (n = p; n < tgt; n++) order_slot[n] = order_slot[n + 1];
        else for (n = p; n > tgt; n--) order_slot[n] = order_slot[n - 1];
        order_slot[tgt] = s;
        tag_of[s] = t;
        newer[s] = mru;
        older[mru] = s;
        mru = s;
        lru = older[s];
        r.present = 1'b1; r.slot = s;
      end
    end
    expected_words.push_back(r);
  endtask

  // request driver with random gaps between words
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) lookup_word('{tag: req_tag, alloc: req_alloc});
        if (gap_cnt > 0 && !(in_valid && gap_cnt == 0)) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pend_words.size() > 0) begin
          req_t w;
          w = pend_words.pop_front();
          req_tag <= w.tag;
          req_alloc <= w.alloc;
          in_valid <= 1'b1;
          gap_cnt <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and random output stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        resp_t got, exp_w;
        int d;
        got = '{present: present, hit: hit, slot: slot, tag: final_tag};
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp present %b hit %b slot %0d tag %h, got %b %b %0d %h",
                       exp_w.present, exp_w.hit, exp_w.slot, exp_w.tag,
                       got.present, got.hit, got.slot, got.tag);
          end
        end
        d = no_idle ? 0 : $urandom_range(0, 3);
        stall_cnt <= d;
        out_stall <= (d != 0);
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= (stall_cnt > 1);
      end
    end
  end

  // timeout
  always @(posedge clk)
    if (cycles > LIMIT) begin
      $display("lru_tag_cache_sorted_index test failed");
      $finish;
    end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 3'b000}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SPACE_INDEX:  space_idx = val[SPACE_W-1:0];
      REG_EMPTY_CODE:   empty_code = val;
      REG_UNKNOWN_CODE: unknown_code = val;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one random request: pool tags, serial-style tags, empty code allocations, new, random or sentinel tags
  function automatic req_t rand_word();
    req_t w;
    int k;
    k = $urandom_range(0, 99);
    w.alloc = 1'($urandom_range(0, 1));
    if (k < 30 && tag_pool.size() > 0) w.tag = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    else if (k < 40) w.tag = {space_idx, SERIAL_W'($urandom_range(0, 60))};
    else if (k < 62) begin w.tag = empty_code; w.alloc = 1'b1; end
    else if (k < 80) begin
      w.tag = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 200));
      w.alloc = 1'b1;
      tag_pool.push_back(w.tag);
      if (tag_pool.size() > 90) void'(tag_pool.pop_front());
    end else if (k < 92) w.tag = rand64();
    else w.tag = ($urandom_range(0, 1)) ? empty_code : unknown_code;
    return w;
  endfunction

  task automatic drain();
    wait (pend_words.size() == 0 && !in_valid && expected_words.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int s;
    for (s = 0; s < 64; s++) begin
      tag_of[s] = (s < NSLOT) ? 64'(s) : '0;
      order_slot[s] = (s < NSLOT) ? IB'(s) : '0;
      older[s] = IB'(s - 1);
      newer[s] = IB'(s + 1);
    end
    mru = '0; lru = IB'(NSLOT - 1); serial = '0;
    space_idx = '0; empty_code = '0; unknown_code = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words: generation, sentinels, hits, misses, tag extremes
    pend_words.push_back('{tag: 64'd0, alloc: 1'b1});
    pend_words.push_back('{tag: 64'd0, alloc: 1'b1});
    pend_words.push_back('{tag: 64'd0, alloc: 1'b0});
    pend_words.push_back('{tag: '1, alloc: 1'b1});
    pend_words.push_back('{tag: 64'd62, alloc: 1'b0});
    pend_words.push_back('{tag: 64'd30, alloc: 1'b1});
    pend_words.push_back('{tag: 64'd100, alloc: 1'b0});
    pend_words.push_back('{tag: 64'd100, alloc: 1'b1});
    pend_words.push_back('{tag: 64'd100, alloc: 1'b0});
    pend_words.push_back('{tag: 64'hFFFF_FFFF_FFFF_FFFE, alloc: 1'b1});
    pend_words.push_back('{tag: 64'h8000_0000_0000_0000, alloc: 1'b1});
    pend_words.push_back('{tag: 64'h5555_5555_5555_5555, alloc: 1'b1});
    pend_words.push_back('{tag: 64'hAAAA_AAAA_AAAA_AAAA, alloc: 1'b1});
    pend_words.push_back('{tag: 64'hFFFF_FFFF_FFFF_FFFE, alloc: 1'b0});
    pend_words.push_back('{tag: 64'd1, alloc: 1'b0});
    drain();

    // phases with different register settings, sender waits between them
    for (s = 0; s < 6; s++) begin
      case (s)
        0: begin reg_write(REG_SPACE_INDEX, 64'd0); reg_write(REG_EMPTY_CODE, 64'd0);
                 reg_write(REG_UNKNOWN_CODE, '1); end
        1: begin reg_write(REG_SPACE_INDEX, 64'd255); reg_write(REG_EMPTY_CODE, '1);
                 reg_write(REG_UNKNOWN_CODE, 64'd0); end
        5: begin reg_write(REG_SPACE_INDEX, 64'd0); reg_write(REG_EMPTY_CODE, 64'd0);
                 reg_write(REG_UNKNOWN_CODE, '1); end
        default: begin reg_write(REG_SPACE_INDEX, 64'($urandom_range(0, 255)));
                 reg_write(REG_EMPTY_CODE, rand64()); reg_write(REG_UNKNOWN_CODE, rand64()); end
      endcase
      no_idle = (s == 3);
      repeat (150) pend_words.push_back(rand_word());
      drain();
    end

    if (errors == 0) $display("lru_tag_cache_sorted_index test passed");
    else $display("lru_tag_cache_sorted_index test failed");
    $finish;
  end
endmodule

// File: files.f
sv/lrutc_pkg.sv
sv/lrutc_cell.sv
sv/lru_tag_cache_sorted_index.sv
verif/testbench.sv
